// File: design/mpts_pkg.sv
// Package: shared types, pattern tables and character folding for the text indicator scanner.
`timescale 1ns / 1ps

package mpts_pkg;

   // Pattern groups: clipboard commands, the encoded flag, stealer names, temp paths
   localparam int unsigned NumCmd     = 13;
   localparam int unsigned CmdFirst   = 0;
   localparam int unsigned EncIdx     = 13;
   localparam int unsigned NumStl     = 6;
   localparam int unsigned StlFirst   = 14;
   localparam int unsigned NumTmp     = 5;
   localparam int unsigned TmpFirst   = 20;
   localparam int unsigned NumPat     = 25;
   localparam int unsigned MaxPatLen  = 32;
   localparam int unsigned CharWidth  = 16;

   // Mode codes
   localparam logic [1:0] ModeCmd   = 2'd0;
   localparam logic [1:0] ModeImage = 2'd1;
   localparam logic [1:0] ModeFile  = 2'd2;

   localparam logic [CharWidth-1:0] Backslash = 16'h005C;

   typedef struct packed {
      logic [1:0]           mode;
      logic [CharWidth-1:0] character;
      logic                 last;
   } req_payload_type;

   typedef struct packed {
      logic clipboard_command;
      logic encoded_command;
      logic known_stealer;
      logic temp_path;
   } rsp_payload_type;

   // Per-character control broadcast along every row of cells
   typedef struct packed {
      logic                 step;   // item accepted this cycle
      logic                 flush;  // accepted item is the last one: clear progress
      logic [CharWidth-1:0] fchar;  // case-folded character
   } scan_ctrl_type;

   // ASCII-only upper-case folding
   function automatic logic [CharWidth-1:0] fold_char(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] r;
      r = c;
      if (c >= 16'h0061 && c <= 16'h007A) begin
         r = c - 16'h0020;
      end
      return r;
   endfunction

   // Pattern text, right-aligned, zero-padded on the left
   function automatic logic [8*MaxPatLen-1:0] pattern_text(input int unsigned idx);
      logic [8*MaxPatLen-1:0] t;
      case (idx)
         0:       t = "Get-Clipboard";
         1:       t = "Set-Clipboard";
         2:       t = "clip.exe";
         3:       t = "[System.Windows.Forms.Clipboard]";
         4:       t = {"win32_", "clipboard"};
         5:       t = "xclip";
         6:       t = "xsel";
         7:       t = "pbcopy";
         8:       t = "ClipboardData";
         9:       t = "GetClipboardData";
         10:      t = "OpenClipboard";
         11:      t = "OleGetClipboard";
         12:      t = "Add-Type.*Clipboard";
         13:      t = "-enc";
         14:      t = "cliplogger";
         15:      t = "clipstealer";
         16:      t = "clipgrab";
         17:      t = {"clipboard", "_monitor"};
         18:      t = "clipboardspy";
         19:      t = {"clipsvc", "_exploit"};
         20:      t = "\\Temp\\";
         21:      t = "\\AppData\\Local\\Temp\\";
         22:      t = "\\AppData\\Roaming\\";
         23:      t = "\\Local Settings\\Temp\\";
         24:      t = "\\$Recycle.Bin\\";
         default: t = "?";
      endcase
      return t;
   endfunction

   // Length = position of the highest nonzero byte
   function automatic int unsigned pattern_len(input int unsigned idx);
      logic [8*MaxPatLen-1:0] t;
      int unsigned            n;
      t = pattern_text(idx);
      n = 0;
      for (int unsigned i = 0; i < MaxPatLen; i++) begin
         if (t[8*i +: 8] != 8'h00) begin
            n = i + 1;
         end
      end
      return n;
   endfunction

   // Folded character at position pos, counted from the start of the pattern
   function automatic logic [7:0] pattern_char(input int unsigned idx, input int unsigned pos);
      logic [8*MaxPatLen-1:0] t;
      logic [CharWidth-1:0]   c;
      int unsigned            n;
      t = pattern_text(idx);
      n = pattern_len(idx);
      c = {8'h00, t[8*(n-1-pos) +: 8]};
      c = fold_char(c);
      return c[7:0];
   endfunction

endpackage

// File: design/mpts_stream_if.sv
// Interface: valid/ready stream channel carrying one payload item.
`timescale 1ns / 1ps

interface mpts_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: design/multi_pattern_text_indicator_scanner_core.sv
// Top level: text indicator scanner with one cell row per pattern and a result register.
// Latency: the result is valid the cycle after the item with last set is accepted.
// Throughput: one character per cycle; each cell does one compare and one AND per character.
// Any input item stalls while a result waits and the consumer does not take it that cycle.
// Reset (synchronous, active high) clears all progress bits, match flags and result valid.
`timescale 1ns / 1ps

module multi_pattern_text_indicator_scanner_core (
   input  logic           clock,
   input  logic           reset,
   mpts_stream_if.sink    req_stream,
   mpts_stream_if.source  rsp_stream
);

   mpts_pkg::scan_ctrl_type          ctrl;
   logic [mpts_pkg::NumPat-1:0]      hits;
   logic                             req_fire;
   logic                             flush;

   logic cmd_seen_ff, cmd_seen_in, cmd_now;
   logic enc_seen_ff, enc_seen_in, enc_now;
   logic stl_seen_ff, stl_seen_in, stl_now;
   logic tmp_seen_ff, tmp_seen_in, tmp_now;

   logic                      rsp_valid_ff, rsp_valid_in;
   mpts_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [1:0]                mode;

   // Input handshake: the result register frees up when the consumer takes it
   assign req_stream.ready = !rsp_valid_ff || rsp_stream.ready;
   assign req_fire         = req_stream.valid && req_stream.ready;
   assign flush            = req_fire && req_stream.data.last;
   assign mode             = req_stream.data.mode;

   assign ctrl.step  = req_fire;
   assign ctrl.flush = flush;
   assign ctrl.fchar = mpts_pkg::fold_char(req_stream.data.character);

   // One row of cells per pattern
   for (genvar p = 0; p < mpts_pkg::NumPat; p++) begin : g_row
      mpts_row #(.PatIdx(p)) u_row (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .hit   (hits[p])
      );
   end

   // Match flags including the current character
   assign cmd_now = cmd_seen_ff || (|hits[mpts_pkg::CmdFirst +: mpts_pkg::NumCmd]);
   assign enc_now = enc_seen_ff || hits[mpts_pkg::EncIdx];
   // A backslash starts a new path component for the stealer names
   assign stl_now = (stl_seen_ff && (ctrl.fchar != mpts_pkg::Backslash))
                    || (|hits[mpts_pkg::StlFirst +: mpts_pkg::NumStl]);
   assign tmp_now = tmp_seen_ff || (|hits[mpts_pkg::TmpFirst +: mpts_pkg::NumTmp]);

   always_comb begin
      cmd_seen_in = cmd_seen_ff;
      enc_seen_in = enc_seen_ff;
      stl_seen_in = stl_seen_ff;
      tmp_seen_in = tmp_seen_ff;
      if (req_fire) begin
         cmd_seen_in = cmd_now && !flush;
         enc_seen_in = enc_now && !flush;
         stl_seen_in = stl_now && !flush;
         tmp_seen_in = tmp_now && !flush;
      end
   end

   // Result register: fields gated by the mode of the last item
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_stream.ready;
      rsp_data_in  = rsp_data_ff;
      if (flush) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.clipboard_command = (mode == mpts_pkg::ModeCmd) && cmd_now;
         rsp_data_in.encoded_command   = (mode == mpts_pkg::ModeCmd) && cmd_now && enc_now;
         rsp_data_in.known_stealer     = (mode == mpts_pkg::ModeImage) && stl_now;
         rsp_data_in.temp_path         = (mode == mpts_pkg::ModeFile) && tmp_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_seen_ff  <= 1'b0;
         enc_seen_ff  <= 1'b0;
         stl_seen_ff  <= 1'b0;
         tmp_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_seen_ff  <= cmd_seen_in;
         enc_seen_ff  <= enc_seen_in;
         stl_seen_ff  <= stl_seen_in;
         tmp_seen_ff  <= tmp_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_stream.valid = rsp_valid_ff;
   assign rsp_stream.data  = rsp_data_ff;

   // A new result only follows an accepted last character
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire && req_stream.data.last))
      else $error("result appeared without a last character");

   // Flags are cleared once a string ends
   a_flags_clear: assert property (@(posedge clock) disable iff (reset)
      flush |=> !cmd_seen_ff && !enc_seen_ff && !stl_seen_ff && !tmp_seen_ff)
      else $error("match flags not cleared after end of string");

   // Encoded flag never without a clipboard hit; modes are exclusive
   a_fields_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.encoded_command || rsp_data_ff.clipboard_command)
                       && $onehot0({rsp_data_ff.clipboard_command,
                                    rsp_data_ff.known_stealer,
                                    rsp_data_ff.temp_path}))
      else $error("inconsistent result fields");

endmodule

// File: design/mpts_cell.sv
// Cell: one pattern position holding one shift-and progress bit.
`timescale 1ns / 1ps

module mpts_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mpts_pkg::scan_ctrl_type ctrl,
   input  logic [7:0]             pat_char,
   input  logic                   prev_bit,
   output logic                   match_bit,
   output logic                   match_next
);

   logic match_ff;
   logic match_in;
   logic eq;

   // Compare against this position's pattern character
   assign eq         = (ctrl.fchar == {8'h00, pat_char});
   assign match_next = prev_bit & eq;

   // Progress update; the last character of a string clears it
   always_comb begin
      match_in = match_ff;
      if (ctrl.step) begin
         match_in = ctrl.flush ? 1'b0 : match_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match_bit = match_ff;

endmodule

// File: design/mpts_row.sv
// Row: chain of cells tracking one pattern; flags a full match.
`timescale 1ns / 1ps

module mpts_row #(
   parameter int unsigned PatIdx = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mpts_pkg::scan_ctrl_type ctrl,
   output logic                    hit
);

   localparam int unsigned Len = mpts_pkg::pattern_len(PatIdx);

   logic [Len-1:0] prog;
   logic [Len-1:0] nxt;

   // Each cell takes its neighbor's stored bit; the first always starts a match
   for (genvar k = 0; k < Len; k++) begin : g_cell
      localparam logic [7:0] PatChar = mpts_pkg::pattern_char(PatIdx, k);
      logic prev;
      if (k == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_body
         assign prev = prog[k-1];
      end
      mpts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .pat_char   (PatChar),
         .prev_bit   (prev),
         .match_bit  (prog[k]),
         .match_next (nxt[k])
      );
   end

   // Whole pattern matched on the current character
   assign hit = nxt[Len-1];

endmodule

// File: verif/multi_pattern_text_indicator_scanner_core_test.sv
// Testbench: multi_pattern_text_indicator_scanner_core, directed strings then random strings.
`timescale 1ns / 1ps

module multi_pattern_text_indicator_scanner_core_test;

   // No mode carries a meaning for this code
   localparam logic [1:0] ModeNone = 2'd3;

   logic clock;
   logic reset;

   mpts_stream_if #(.payload_type(mpts_pkg::req_payload_type)) req_if ();
   mpts_stream_if #(.payload_type(mpts_pkg::rsp_payload_type)) rsp_if ();

   multi_pattern_text_indicator_scanner_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if)
   );

   // Join two pieces of pattern text
   function automatic string join_text(input string a, input string b);
      return {a, b};
   endfunction

   // Pattern text per group; "." and "*" are literal characters
   string cmd_pats [mpts_pkg::NumCmd] = '{
      "Get-Clipboard", "Set-Clipboard", "clip.exe", "[System.Windows.Forms.Clipboard]",
      join_text("win32_", "clipboard"), "xclip", "xsel", "pbcopy", "ClipboardData",
      "GetClipboardData", "OpenClipboard", "OleGetClipboard", "Add-Type.*Clipboard"};
   string enc_pat = "-enc";
   string stl_pats [mpts_pkg::NumStl] = '{
      "cliplogger", "clipstealer", "clipgrab", join_text("clipboard", "_monitor"),
      "clipboardspy", join_text("clipsvc", "_exploit")};
   string tmp_pats [mpts_pkg::NumTmp] = '{
      "\\Temp\\", "\\AppData\\Local\\Temp\\", "\\AppData\\Roaming\\",
      "\\Local Settings\\Temp\\", "\\$Recycle.Bin\\"};

   // Scanner state mirrored by the predictor
   bit [31:0] cmd_prog [mpts_pkg::NumCmd];
   bit [31:0] enc_prog;
   bit [31:0] stl_prog [mpts_pkg::NumStl];
   bit [31:0] tmp_prog [mpts_pkg::NumTmp];
   bit        cmd_seen, enc_seen, stl_seen, tmp_seen;

   mpts_pkg::rsp_payload_type pending_verdicts [$];

   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   int strings_sent;
   int verdicts_checked;
   int failures;
   int hit_count [4];

   // Clock and reset
   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic logic [15:0] upcase_ascii(input logic [15:0] c);
      if (c >= 16'h0061 && c <= 16'h007A) begin
         return c - 16'h0020;
      end
      return c;
   endfunction

   // One shift-and step; returns the top bit (whole pattern matched)
   function automatic bit shift_and_step(inout bit [31:0] prog, input string pat,
                                         input logic [15:0] fc);
      bit [31:0] eq;
      eq = '0;
      for (int k = 0; k < pat.len(); k++) begin
         if (upcase_ascii({8'h00, pat[k]}) == fc) eq[k] = 1'b1;
      end
      prog = ((prog << 1) | 32'd1) & eq;
      return prog[pat.len()-1];
   endfunction

   function automatic void clear_scan_state();
      foreach (cmd_prog[i]) cmd_prog[i] = '0;
      foreach (stl_prog[i]) stl_prog[i] = '0;
      foreach (tmp_prog[i]) tmp_prog[i] = '0;
      enc_prog = '0;
      cmd_seen = 1'b0;
      enc_seen = 1'b0;
      stl_seen = 1'b0;
      tmp_seen = 1'b0;
   endfunction

   // Advance every pattern on one character; a verdict comes with the last one
   function automatic void scan_character(input mpts_pkg::req_payload_type it,
                                          output bit done,
                                          output mpts_pkg::rsp_payload_type verdict);
      logic [15:0] fc;
      fc = upcase_ascii(it.character);
      foreach (cmd_prog[i]) begin
         if (shift_and_step(cmd_prog[i], cmd_pats[i], fc)) cmd_seen = 1'b1;
      end
      if (shift_and_step(enc_prog, enc_pat, fc)) enc_seen = 1'b1;
      // backslash starts a new path component
      if (it.character == mpts_pkg::Backslash) stl_seen = 1'b0;
      foreach (stl_prog[i]) begin
         if (shift_and_step(stl_prog[i], stl_pats[i], fc)) stl_seen = 1'b1;
      end
      foreach (tmp_prog[i]) begin
         if (shift_and_step(tmp_prog[i], tmp_pats[i], fc)) tmp_seen = 1'b1;
      end
      done = it.last;
      verdict.clipboard_command = (it.mode == mpts_pkg::ModeCmd) && cmd_seen;
      verdict.encoded_command   = (it.mode == mpts_pkg::ModeCmd) && cmd_seen && enc_seen;
      verdict.known_stealer     = (it.mode == mpts_pkg::ModeImage) && stl_seen;
      verdict.temp_path         = (it.mode == mpts_pkg::ModeFile) && tmp_seen;
      if (it.last) clear_scan_state();
   endfunction

   // Receiver: random stalls per the current mix
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check accepted verdicts first, then predict from the accepted character
   always @(posedge clock) begin
      mpts_pkg::rsp_payload_type exp_v;
      mpts_pkg::rsp_payload_type got_v;
      mpts_pkg::rsp_payload_type new_v;
      bit                        done;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got_v = rsp_if.data;
            if (pending_verdicts.size() == 0) begin
               failures++;
               if (failures <= 10) $display("ERROR: verdict %b with none expected", got_v);
            end else begin
               exp_v = pending_verdicts.pop_front();
               verdicts_checked++;
               if (got_v.clipboard_command !== exp_v.clipboard_command ||
                   got_v.encoded_command   !== exp_v.encoded_command   ||
                   got_v.known_stealer     !== exp_v.known_stealer     ||
                   got_v.temp_path         !== exp_v.temp_path) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("ERROR: verdict %0d clip/enc/stealer/temp exp %b%b%b%b got %b%b%b%b",
                              verdicts_checked, exp_v.clipboard_command,
                              exp_v.encoded_command, exp_v.known_stealer, exp_v.temp_path,
                              got_v.clipboard_command, got_v.encoded_command,
                              got_v.known_stealer, got_v.temp_path);
                  end
               end
               if (exp_v.clipboard_command) hit_count[0]++;
               if (exp_v.encoded_command) hit_count[1]++;
               if (exp_v.known_stealer) hit_count[2]++;
               if (exp_v.temp_path) hit_count[3]++;
            end
         end
         if (req_if.valid && req_if.ready) begin
            scan_character(req_if.data, done, new_v);
            if (done) pending_verdicts.push_back(new_v);
         end
      end
   end

   // Send one character; returns at the edge where it was accepted
   task automatic send_item(input logic [1:0] mode, input logic [15:0] ch, input logic last);
      mpts_pkg::req_payload_type it;
      int gap;
      it.mode      = mode;
      it.character = ch;
      it.last      = last;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= it;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      if (last) strings_sent++;
   endtask

   task automatic send_text(input logic [1:0] mode, input string s);
      for (int k = 0; k < s.len(); k++) begin
         send_item(mode, {8'h00, s[k]}, k == s.len() - 1);
      end
   endtask

   // Append pattern text with random letter case, sometimes broken
   task automatic add_fragment(ref logic [15:0] q[$], input string s, input bit broken);
      int cut;
      int skip;
      logic [15:0] c;
      cut  = s.len();
      skip = -1;
      if (broken && s.len() > 1) begin
         if ($urandom_range(1)) cut = $urandom_range(s.len() - 1, 1);
         else skip = $urandom_range(s.len() - 1);
      end
      for (int k = 0; k < cut; k++) begin
         if (k != skip) begin
            c = {8'h00, s[k]};
            if (upcase_ascii(c | 16'h0020) == (c & ~16'h0020) &&
                (c & ~16'h0020) >= 16'h0041 && (c & ~16'h0020) <= 16'h005A &&
                $urandom_range(1))
               c = c ^ 16'h0020;
            q.push_back(c);
         end
      end
   endtask

   function automatic string group_pattern(input int grp);
      case (grp)
         0:       return ($urandom_range(4) == 0) ? "-EncodedCommand" :
                         ($urandom_range(3) == 0) ? enc_pat :
                         cmd_pats[$urandom_range(mpts_pkg::NumCmd-1)];
         1:       return stl_pats[$urandom_range(mpts_pkg::NumStl-1)];
         default: return tmp_pats[$urandom_range(mpts_pkg::NumTmp-1)];
      endcase
   endfunction

   // Random string: pattern pieces for its mode mixed with noise
   task automatic send_random_string();
      logic [15:0] chars [$];
      logic [1:0]  mode;
      logic [1:0]  this_mode;
      bit          mixed;
      int          nfrag;
      int          pick;
      int          grp;
      mode  = ($urandom_range(99) < 8) ? ModeNone : 2'($urandom_range(2));
      mixed = ($urandom_range(99) < 12);
      grp   = (mode == ModeNone) ? $urandom_range(2) : int'(mode);
      nfrag = $urandom_range(4, 1);
      for (int f = 0; f < nfrag; f++) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            add_fragment(chars, group_pattern(grp), $urandom_range(99) < 15);
         end else if (pick < 62) begin
            add_fragment(chars, group_pattern($urandom_range(2)), $urandom_range(99) < 15);
         end else if (pick < 78) begin
            repeat ($urandom_range(6, 1)) chars.push_back(16'($urandom_range(16'h7E, 16'h20)));
         end else if (pick < 86) begin
            chars.push_back(mpts_pkg::Backslash);
         end else if (pick < 93) begin
            chars.push_back(16'($urandom_range(16'hFFFF)));
         end else begin
            case ($urandom_range(5))
               0:       chars.push_back(16'h0000);
               1:       chars.push_back(16'hFFFF);
               2:       chars.push_back(16'h0060);
               3:       chars.push_back(16'h007B);
               4:       chars.push_back(16'h007C);
               // a letter's low byte under a nonzero high byte must not match
               default: chars.push_back({8'($urandom_range(255, 1)),
                                         8'($urandom_range(16'h5A, 16'h41))});
            endcase
         end
      end
      // image paths: often a stealer name in or before the final component
      if (grp == 1 && $urandom_range(99) < 40) begin
         if ($urandom_range(1)) chars.push_back(mpts_pkg::Backslash);
         add_fragment(chars, group_pattern(1), $urandom_range(99) < 10);
         if ($urandom_range(99) < 25) chars.push_back(mpts_pkg::Backslash);
      end
      if (chars.size() == 0) chars.push_back(16'($urandom_range(16'hFFFF)));
      foreach (chars[k]) begin
         this_mode = mixed ? 2'($urandom_range(3)) : mode;
         send_item(this_mode, chars[k], k == chars.size() - 1);
      end
   endtask

   // Directed: hits in each mode, extremes, mode 3, backslash and mode switching
   task automatic test_directed();
      send_idle_pct = 15;
      recv_idle_pct = 74;
      send_text(mpts_pkg::ModeCmd, "xSel -enc");
      send_text(ModeNone, "xsel");
      send_text(mpts_pkg::ModeImage, "ClipGrab\\x");
      send_item(mpts_pkg::ModeFile, 16'h0000, 1'b0);
      send_item(mpts_pkg::ModeFile, 16'hFFFF, 1'b0);
      send_text(mpts_pkg::ModeFile, "\\TEMP\\");
      // patterns searched in every mode; the final mode picks the fields
      send_item(mpts_pkg::ModeFile, {8'h00, "x"}, 1'b0);
      send_item(mpts_pkg::ModeImage, {8'h00, "c"}, 1'b0);
      send_item(ModeNone, {8'h00, "L"}, 1'b0);
      send_item(mpts_pkg::ModeFile, {8'h00, "i"}, 1'b0);
      send_item(mpts_pkg::ModeCmd, {8'h00, "p"}, 1'b1);
      send_item(mpts_pkg::ModeFile, 16'hFFFF, 1'b1);
   endtask

   task automatic test_random_mix(input int snd_pct, input int rcv_pct, input int n);
      int target;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      target = items_sent + n;
      while (items_sent < target) send_random_string();
   endtask

   // Run limit
   initial begin
      #2_000_000;
      $display("ERROR: run did not finish in time");
      $display("** multi_pattern_text_indicator_scanner_core: FAILED **");
      $finish;
   end

   // Main sequence
   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      items_sent = 0;
      strings_sent = 0;
      verdicts_checked = 0;
      failures = 0;
      foreach (hit_count[i]) hit_count[i] = 0;
      clear_scan_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix(15, 74, 520);
      test_random_mix(74, 15, 520);
      test_random_mix(0, 0, 510);

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d strings (%0d characters) over three idle mixes; %0d verdicts checked",
               strings_sent, items_sent, verdicts_checked);
      $display("Hits: clipboard %0d, encoded %0d, stealer %0d, temp %0d; failures %0d",
               hit_count[0], hit_count[1], hit_count[2], hit_count[3], failures);
      if (failures == 0) begin
         $display("** multi_pattern_text_indicator_scanner_core: PASSED **");
      end else begin
         $display("** multi_pattern_text_indicator_scanner_core: FAILED **");
      end
      $finish;
   end

endmodule
